// ===== design/ilbm_p2c_pkg.sv =====
// ----------------------------------------------------------------------------
// ilbm_p2c_pkg
// Shared types, limits and a helper function for the interleaved-bitplane
// ByteRun1 planar-to-chunky core.
// ----------------------------------------------------------------------------
package ilbm_p2c_pkg;

   localparam int MAX_WIDTH  = 512;
   localparam int MAX_HEIGHT = 512;
   localparam int MAX_PLANES = 8;
   localparam int GROUPS     = (MAX_WIDTH + 15) / 16 * 2;
   localparam int GROUP_AW   = $clog2(GROUPS);

   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_PLANE_COUNT  = 2'd2;
   localparam logic [1:0] CSR_COMPRESSED   = 2'd3;

   typedef enum logic [1:0] {
      PH_CMD = 2'd0,
      PH_LIT = 2'd1,
      PH_REP = 2'd2
   } phase_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_PUT  = 1'b1
   } state_type;

   // Places bit k of a plane byte into pixel k's index at the given plane bit.
   function automatic logic [63:0] spread(input logic [7:0] b, input logic [2:0] plane);
      logic [63:0] r;
      r = '0;
      for (int k = 0; k < 8; k++) begin
         r[8 * k + int'(plane)] = b[k];
      end
      return r;
   endfunction

endpackage

// ===== design/ilbm_byterun1_planar_to_chunky_core.sv =====
// ----------------------------------------------------------------------------
// ilbm_byterun1_planar_to_chunky_core
// Decodes an interleaved-bitplane image body (ByteRun1 or raw) and merges
// plane bytes into a row store, emitting eight chunky pixels per group.
// ----------------------------------------------------------------------------
//  Channel  Direction  Beat contents
//  req_     in         one body byte
//  rsp_     out        pixel group, valid mask, column, row, flags
//  csr_     in         register index and write data, no read-back
//
// A command byte is taken in the idle state and writes nothing. A literal or
// raw byte first reads the row store entry, then merges, writes back and emits.
// A repeat byte reads and then merges each group it fills in turn; the row
// store read of the next group overlaps the write of the current one.
// A stalled result holds the merge stage. Reset is synchronous and needs
// no clearing pass; the row store is filled by plane zero of each row.
module ilbm_byterun1_planar_to_chunky_core
   import ilbm_p2c_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_body_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_pixel_group,
   output logic [7:0]  rsp_pixel_valid,
   output logic [5:0]  rsp_group_column,
   output logic [8:0]  rsp_row_index,
   output logic        rsp_last_of_input,
   output logic        rsp_frame_done,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_write_data
);

   logic [9:0]  width_ff, height_ff;
   logic [3:0]  planes_ff;
   logic        compressed_ff;

   state_type   state_ff, state_in;
   phase_type   phase_ff, phase_in;
   logic [7:0]  run_ff, run_in;
   logic [8:0]  row_ff, row_in;
   logic [2:0]  plane_ff, plane_in;
   logic [6:0]  column_ff, column_in;
   logic [7:0]  byte_ff, byte_in;
   logic [7:0]  puts_ff, puts_in;
   logic        bnd_ff, bnd_in;

   logic [63:0] row_store_ff [GROUPS];
   logic [63:0] rd_data_ff;
   logic        mem_re, mem_we;
   logic [GROUP_AW-1:0] mem_raddr;
   logic [63:0] merged;

   logic        out_valid_ff, out_valid_in;
   logic [63:0] out_group_ff;
   logic [7:0]  out_mask_ff, out_mask_in;
   logic [5:0]  out_col_ff;
   logic [8:0]  out_row_ff;
   logic        out_last_ff, out_last_in;
   logic        out_done_ff, out_done_in;
   logic        out_load;

   logic [9:0]  eff_w, eff_h;
   logic [3:0]  eff_p;
   logic [9:0]  w_pad;
   logic [6:0]  gpr;

   logic [6:0]  bnd_src, bnd_col;
   logic [2:0]  bnd_plane;
   logic [8:0]  bnd_row;
   logic [3:0]  plane_p1;
   logic [9:0]  row_p1;

   logic [6:0]  col_inc;
   logic [7:0]  puts_dec;
   logic        emit, stall, more;

   always_comb begin
      eff_w = (width_ff == '0) ? 10'd1 :
              (width_ff > 10'(MAX_WIDTH)) ? 10'(MAX_WIDTH) : width_ff;
      eff_h = (height_ff == '0) ? 10'd1 :
              (height_ff > 10'(MAX_HEIGHT)) ? 10'(MAX_HEIGHT) : height_ff;
      eff_p = (planes_ff == '0) ? 4'd1 :
              (planes_ff > 4'(MAX_PLANES)) ? 4'(MAX_PLANES) : planes_ff;
      w_pad = eff_w + 10'd15;
      gpr   = {w_pad[9:4], 1'b0};
   end

   assign col_inc  = column_ff + 7'd1;
   assign puts_dec = puts_ff - 8'd1;
   assign merged   = (plane_ff == '0) ? spread(byte_ff, 3'd0)
                                      : (rd_data_ff | spread(byte_ff, plane_ff));
   assign emit     = ({1'b0, plane_ff} + 4'd1) >= eff_p;
   assign stall    = emit && out_valid_ff && !rsp_ready;
   assign more     = (puts_dec != '0) && (col_inc < gpr);

   // Row end handling: next plane, then next row, then wrap to the frame start.
   always_comb begin
      bnd_src  = (state_ff == ST_IDLE) ? column_ff : col_inc;
      plane_p1 = {1'b0, plane_ff} + 4'd1;
      row_p1   = {1'b0, row_ff} + 10'd1;
      bnd_col   = bnd_src;
      bnd_plane = plane_ff;
      bnd_row   = row_ff;
      if (bnd_src >= gpr) begin
         bnd_col = '0;
         if (plane_p1 >= eff_p) begin
            bnd_plane = '0;
            bnd_row   = (row_p1 >= eff_h) ? 9'd0 : row_p1[8:0];
         end else begin
            bnd_plane = plane_p1[2:0];
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      run_in    = run_ff;
      row_in    = row_ff;
      plane_in  = plane_ff;
      column_in = column_ff;
      byte_in   = byte_ff;
      puts_in   = puts_ff;
      bnd_in    = bnd_ff;
      mem_re    = 1'b0;
      mem_we    = 1'b0;
      mem_raddr = column_ff[GROUP_AW-1:0];
      out_load  = 1'b0;
      req_ready = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               byte_in = req_body_byte;
               if (!compressed_ff) begin
                  phase_in = PH_CMD;
                  run_in   = '0;
                  puts_in  = 8'd1;
                  bnd_in   = 1'b1;
               end else begin
                  case (phase_ff)
                     PH_LIT: begin
                        run_in   = (run_ff != '0) ? run_ff - 8'd1 : run_ff;
                        puts_in  = 8'd1;
                        bnd_in   = (run_in == '0);
                        phase_in = (run_in == '0) ? PH_CMD : PH_LIT;
                     end
                     PH_REP: begin
                        puts_in  = run_ff;
                        run_in   = '0;
                        bnd_in   = 1'b1;
                        phase_in = PH_CMD;
                     end
                     default: begin
                        puts_in = '0;
                        bnd_in  = 1'b0;
                        if (req_body_byte < 8'd128) begin
                           phase_in = PH_LIT;
                           run_in   = req_body_byte + 8'd1;
                        end else if (req_body_byte > 8'd128) begin
                           phase_in = PH_REP;
                           run_in   = 8'(9'd257 - {1'b0, req_body_byte});
                        end else begin
                           phase_in = PH_CMD;
                           run_in   = '0;
                        end
                     end
                  endcase
               end
               if ((puts_in != '0) && (column_ff < gpr)) begin
                  mem_re   = 1'b1;
                  state_in = ST_PUT;
               end else if (bnd_in) begin
                  column_in = bnd_col;
                  plane_in  = bnd_plane;
                  row_in    = bnd_row;
               end
            end
         end
         ST_PUT: begin
            if (!stall) begin
               mem_we   = 1'b1;
               out_load = emit;
               puts_in  = puts_dec;
               if (more) begin
                  column_in = col_inc;
                  mem_re    = 1'b1;
                  mem_raddr = col_inc[GROUP_AW-1:0];
               end else begin
                  state_in  = ST_IDLE;
                  column_in = col_inc;
                  if (bnd_ff) begin
                     column_in = bnd_col;
                     plane_in  = bnd_plane;
                     row_in    = bnd_row;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         out_mask_in[7 - i] = {1'b0, column_ff[5:0], 3'(i)} < eff_w;
      end
      out_last_in  = !more;
      out_done_in  = (col_inc == gpr) && (({1'b0, row_ff} + 10'd1) >= eff_h);
      out_valid_in = out_load || (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= 10'd320;
         height_ff     <= 10'd200;
         planes_ff     <= 4'd8;
         compressed_ff <= 1'b1;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff      <= csr_write_data;
            CSR_IMAGE_HEIGHT: height_ff     <= csr_write_data;
            CSR_PLANE_COUNT:  planes_ff     <= csr_write_data[3:0];
            CSR_COMPRESSED:   compressed_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_CMD;
         run_ff       <= '0;
         row_ff       <= '0;
         plane_ff     <= '0;
         column_ff    <= '0;
         puts_ff      <= '0;
         bnd_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         run_ff       <= run_in;
         row_ff       <= row_in;
         plane_ff     <= plane_in;
         column_ff    <= column_in;
         puts_ff      <= puts_in;
         bnd_ff       <= bnd_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      if (out_load) begin
         out_group_ff <= merged;
         out_mask_ff  <= out_mask_in;
         out_col_ff   <= column_ff[5:0];
         out_row_ff   <= row_ff;
         out_last_ff  <= out_last_in;
         out_done_ff  <= out_done_in;
      end
   end

   // The next group is read while the current one is written; the two
   // addresses always differ, so no forwarding is needed.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         row_store_ff[column_ff[GROUP_AW-1:0]] <= merged;
      end
      if (mem_re) begin
         rd_data_ff <= row_store_ff[mem_raddr];
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_pixel_group   = out_group_ff;
   assign rsp_pixel_valid   = out_mask_ff;
   assign rsp_group_column  = out_col_ff;
   assign rsp_row_index     = out_row_ff;
   assign rsp_last_of_input = out_last_ff;
   assign rsp_frame_done    = out_done_ff;

endmodule

// ===== tb/ilbm_p2c_pixel_checker.sv =====
// ----------------------------------------------------------------------------
// ilbm_p2c_pixel_checker
// Watches the body byte, pixel group and register ports of the planar-to-
// chunky core, decodes every accepted body byte on its own copy of the row
// store and counters, and compares each pixel group beat with the oldest
// predicted group. Mismatches are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module ilbm_p2c_pixel_checker
   import ilbm_p2c_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_body_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [63:0] rsp_pixel_group,
   input  logic [7:0]  rsp_pixel_valid,
   input  logic [5:0]  rsp_group_column,
   input  logic [8:0]  rsp_row_index,
   input  logic        rsp_last_of_input,
   input  logic        rsp_frame_done,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [9:0]  csr_write_data,
   output int          mismatch_count,
   output int          groups_outstanding,
   output int          bytes_to_row_end
);

   typedef struct packed {
      logic [63:0] pixels;
      logic [7:0]  mask;
      logic [5:0]  column;
      logic [8:0]  row;
      logic        last;
      logic        done;
   } group_beat_t;

   logic [9:0]  cfg_width;
   logic [9:0]  cfg_height;
   logic [3:0]  cfg_planes;
   logic        cfg_compressed;

   logic [63:0] row_groups [GROUPS];
   int unsigned row_num;
   int unsigned plane_num;
   int unsigned column_num;
   int unsigned run_left;
   phase_type   phase;

   group_beat_t predicted_groups [$];
   int          produced;

   function automatic int unsigned width_px();
      if (cfg_width == 0) return 1;
      if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
      return cfg_width;
   endfunction

   function automatic int unsigned height_rows();
      if (cfg_height == 0) return 1;
      if (cfg_height > MAX_HEIGHT) return MAX_HEIGHT;
      return cfg_height;
   endfunction

   function automatic int unsigned plane_total();
      if (cfg_planes == 0) return 1;
      if (cfg_planes > MAX_PLANES) return MAX_PLANES;
      return cfg_planes;
   endfunction

   function automatic int unsigned groups_in_row();
      return ((width_px() + 15) & 'hFFF0) / 8;
   endfunction

   task automatic emit_group(input int unsigned col);
      group_beat_t g;
      g.pixels = row_groups[col];
      for (int i = 0; i < 8; i++) begin
         g.mask[7 - i] = (col * 8 + i < width_px());
      end
      g.column = 6'(col);
      g.row    = 9'(row_num);
      g.last   = 1'b0;
      g.done   = (col + 1 == groups_in_row()) && (row_num + 1 >= height_rows());
      predicted_groups.push_back(g);
      produced++;
   endtask

   // Bit k of a plane byte is pixel k counted from the right of the group.
   task automatic merge_plane_byte(input logic [7:0] b);
      int unsigned col;
      logic [63:0] bits;
      col = column_num;
      if (col < groups_in_row() && col < GROUPS) begin
         bits = '0;
         for (int k = 0; k < 8; k++) begin
            bits[8 * k + (plane_num % 8)] = b[k];
         end
         if (plane_num == 0) row_groups[col] = bits;
         else row_groups[col] = row_groups[col] | bits;
         if (plane_num + 1 >= plane_total()) emit_group(col);
         column_num = col + 1;
      end
   endtask

   task automatic close_plane_row();
      if (column_num >= groups_in_row()) begin
         column_num = 0;
         plane_num++;
         if (plane_num >= plane_total()) begin
            plane_num = 0;
            row_num++;
            if (row_num >= height_rows()) row_num = 0;
         end
      end
   endtask

   task automatic decode_body_byte(input logic [7:0] b);
      group_beat_t tail;
      produced = 0;
      if (!cfg_compressed) begin
         phase    = PH_CMD;
         run_left = 0;
         merge_plane_byte(b);
         close_plane_row();
      end else begin
         case (phase)
            PH_LIT: begin
               merge_plane_byte(b);
               if (run_left > 0) run_left--;
               if (run_left == 0) begin
                  phase = PH_CMD;
                  close_plane_row();
               end
            end
            PH_REP: begin
               for (int i = 0; i < run_left; i++) begin
                  if (column_num >= groups_in_row()) break;
                  merge_plane_byte(b);
               end
               run_left = 0;
               phase    = PH_CMD;
               close_plane_row();
            end
            default: begin
               if (b < 8'd128) begin
                  phase    = PH_LIT;
                  run_left = int'(b) + 1;
               end else if (b > 8'd128) begin
                  phase    = PH_REP;
                  run_left = 257 - int'(b);
               end else begin
                  phase    = PH_CMD;
                  run_left = 0;
               end
            end
         endcase
      end
      if (produced > 0) begin
         tail = predicted_groups.pop_back();
         tail.last = 1'b1;
         predicted_groups.push_back(tail);
      end
   endtask

   always @(posedge clock) begin
      group_beat_t want;
      group_beat_t got;
      if (reset) begin
         cfg_width      = 10'd320;
         cfg_height     = 10'd200;
         cfg_planes     = 4'd8;
         cfg_compressed = 1'b1;
         row_num        = 0;
         plane_num      = 0;
         column_num     = 0;
         run_left       = 0;
         phase          = PH_CMD;
         mismatch_count = 0;
         predicted_groups.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_pixel_group, rsp_pixel_valid, rsp_group_column, rsp_row_index,
                    rsp_last_of_input, rsp_frame_done};
            if (predicted_groups.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected group beat: pixels %h mask %h col %0d row %0d",
                           got.pixels, got.mask, got.column, got.row);
            end else begin
               want = predicted_groups.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"group mismatch: expected pixels %h mask %h col %0d row %0d",
                               " last %0b done %0b; got pixels %h mask %h col %0d row %0d",
                               " last %0b done %0b"},
                              want.pixels, want.mask, want.column, want.row, want.last,
                              want.done, got.pixels, got.mask, got.column, got.row,
                              got.last, got.done);
               end
            end
         end
         if (csr_write_en) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  cfg_width      = csr_write_data;
               CSR_IMAGE_HEIGHT: cfg_height     = csr_write_data;
               CSR_PLANE_COUNT:  cfg_planes     = csr_write_data[3:0];
               CSR_COMPRESSED:   cfg_compressed = csr_write_data[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) decode_body_byte(req_body_byte);
      end
      groups_outstanding = predicted_groups.size();
      // A plane row that a literal run has already filled is closed by one more raw byte.
      if (plane_num == 0 && column_num == 0) bytes_to_row_end = 0;
      else if (plane_num < plane_total())
         bytes_to_row_end = (plane_total() - 1 - plane_num) * groups_in_row()
                            + ((column_num >= groups_in_row()) ? 1
                               : (groups_in_row() - column_num));
      else bytes_to_row_end = groups_in_row() - column_num;
   end

endmodule

// ===== tb/ilbm_byterun1_planar_to_chunky_core_tb.sv =====
// ----------------------------------------------------------------------------
// ilbm_byterun1_planar_to_chunky_core_tb
// Drives body bytes and register settings into the planar-to-chunky core and
// gives the verdict. A short directed stream covers literal, repeat and no-op
// commands, row end clipping, padding groups and the frame wrap; random
// phases then send well-formed plane rows with some noise under several
// register settings, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module ilbm_byterun1_planar_to_chunky_core_tb;
   import ilbm_p2c_pkg::*;

   localparam int SETTLE_CYCLES  = 100;
   localparam int WATCHDOG_LIMIT = 5000;

   localparam logic [7:0] OPENING [21] = '{
      8'h80, 8'h01, 8'hFF, 8'h00, 8'hFE, 8'hA5, 8'h05, 8'h0F, 8'hF0, 8'h55, 8'hAA,
      8'h12, 8'h34, 8'h81, 8'h3C, 8'hFF, 8'hC3, 8'h01, 8'h80, 8'h7F, 8'h83
   };

   logic        clock;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_ready;
   logic [7:0]  req_body_byte  = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready      = 1'b0;
   logic [63:0] rsp_pixel_group;
   logic [7:0]  rsp_pixel_valid;
   logic [5:0]  rsp_group_column;
   logic [8:0]  rsp_row_index;
   logic        rsp_last_of_input;
   logic        rsp_frame_done;
   logic        csr_write_en   = 1'b0;
   logic [1:0]  csr_index      = CSR_IMAGE_WIDTH;
   logic [9:0]  csr_write_data = 10'd0;

   int mismatch_count;
   int groups_outstanding;
   int bytes_to_row_end;
   int bytes_sent   = 0;
   int stall_pct    = 0;
   int gap_pct      = 0;
   int stall_left   = 0;
   int quiet_cycles = 0;

   ilbm_byterun1_planar_to_chunky_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_body_byte     (req_body_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pixel_group   (rsp_pixel_group),
      .rsp_pixel_valid   (rsp_pixel_valid),
      .rsp_group_column  (rsp_group_column),
      .rsp_row_index     (rsp_row_index),
      .rsp_last_of_input (rsp_last_of_input),
      .rsp_frame_done    (rsp_frame_done),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   ilbm_p2c_pixel_checker pixel_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_body_byte      (req_body_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pixel_group    (rsp_pixel_group),
      .rsp_pixel_valid    (rsp_pixel_valid),
      .rsp_group_column   (rsp_group_column),
      .rsp_row_index      (rsp_row_index),
      .rsp_last_of_input  (rsp_last_of_input),
      .rsp_frame_done     (rsp_frame_done),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .mismatch_count     (mismatch_count),
      .groups_outstanding (groups_outstanding),
      .bytes_to_row_end   (bytes_to_row_end)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // After a stall burst, ready is always raised again before a new burst can start.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!rsp_ready || $urandom_range(0, 99) >= stall_pct) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 5);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("** ilbm_byterun1_planar_to_chunky_core: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic int row_groups(input int w);
      int px;
      px = (w < 1) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
      return (px + 15) / 16 * 2;
   endfunction

   task automatic send_byte(input logic [7:0] b);
      if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_body_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (groups_outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [9:0] value);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= value;
      @(posedge clock);
   endtask

   task automatic program_regs(input logic [9:0] w, input logic [9:0] h,
                               input logic [3:0] p, input logic c);
      write_reg(CSR_IMAGE_WIDTH, w);
      write_reg(CSR_IMAGE_HEIGHT, h);
      write_reg(CSR_PLANE_COUNT, {6'd0, p});
      write_reg(CSR_COMPRESSED, {9'd0, c});
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // In raw mode each byte drops any pending run; raw bytes then finish the row
   // so that new geometry always starts on plane zero.
   task automatic realign();
      int fill;
      write_reg(CSR_COMPRESSED, 10'd0);
      csr_write_en <= 1'b0;
      repeat (2) @(posedge clock);
      fill = bytes_to_row_end;
      repeat (fill) send_byte(8'($urandom));
      wait_idle();
   endtask

   task automatic send_packed_plane(input int groups);
      int left;
      int len;
      left = groups;
      while (left > 0) begin
         if ($urandom_range(0, 9) == 0) send_byte(8'h80);
         if ($urandom_range(0, 1) == 0) len = left;
         else len = $urandom_range(1, left);
         if ($urandom_range(0, 7) == 0) len = len + $urandom_range(1, 3);
         if (len == 1 || (len <= 12 && $urandom_range(0, 1) == 1)) begin
            send_byte(8'(len - 1));
            repeat (len) send_byte(8'($urandom));
         end else begin
            send_byte(8'(257 - len));
            send_byte(8'($urandom));
         end
         left = left - len;
      end
   endtask

   task automatic run_phase(input logic [9:0] w, input logic [9:0] h, input logic [3:0] p,
                            input logic c, input int budget, input int stall, input int gap);
      int groups;
      int planes;
      int start;
      realign();
      stall_pct = stall;
      gap_pct   = gap;
      program_regs(w, h, p, c);
      groups = row_groups(w);
      planes = (p == 0) ? 1 : (p > MAX_PLANES) ? MAX_PLANES : p;
      start  = bytes_sent;
      while (bytes_sent - start < budget) begin
         if (c && groups * planes <= 64 && $urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
         end else begin
            for (int pl = 0; pl < planes; pl++) begin
               if (c) send_packed_plane(groups);
               else repeat (groups) send_byte(8'($urandom));
            end
         end
      end
      if (c && $urandom_range(0, 1) == 1) send_byte(8'($urandom_range(129, 255)));
      wait_idle();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      stall_pct = 20;
      gap_pct   = 20;
      program_regs(10'd20, 10'd2, 4'd2, 1'b1);
      for (int i = 0; i < 21; i++) send_byte(OPENING[i]);
      wait_idle();
      run_phase(10'd1,    10'd3,    4'd1,  1'b0, 30, 30, 30);
      run_phase(10'd512,  10'd512,  4'd8,  1'b1, 30, 20, 10);
      run_phase(10'd37,   10'd1,    4'd3,  1'b1, 40, 40, 0);
      run_phase(10'd100,  10'd5,    4'd4,  1'b0, 40, 0,  30);
      run_phase(10'd0,    10'd0,    4'd0,  1'b0, 20, 25, 25);
      run_phase(10'd1023, 10'd1023, 4'd15, 1'b1, 30, 10, 10);
      run_phase(10'd64,   10'd7,    4'd5,  1'b1, 40, 30, 30);
      run_phase(10'd9,    10'd200,  4'd2,  1'b1, 40, 50, 50);
      run_phase(10'd48,   10'd4,    4'd6,  1'b1, 40, 0,  0);
      if (mismatch_count == 0 && groups_outstanding == 0)
         $display("** ilbm_byterun1_planar_to_chunky_core: PASSED **");
      else
         $display("** ilbm_byterun1_planar_to_chunky_core: FAILED **");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/ilbm_p2c_pkg.sv
design/ilbm_byterun1_planar_to_chunky_core.sv
tb/ilbm_p2c_pixel_checker.sv
tb/ilbm_byterun1_planar_to_chunky_core_tb.sv
